### rtl/sdsch_pkg.sv
package sdsch_pkg;

    localparam int MAX_REQUESTS = 16;
    localparam int POS_W        = 16;
    localparam int SUM_W        = 21;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CFG_IDX_W    = 1;

    localparam logic [POS_W-1:0] DISK_END_RST   = POS_W'(199);
    localparam logic [POS_W-1:0] HEAD_START_RST = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISK_END   = 1'b0,
        CFG_HEAD_START = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MV_NONE = 2'd0,
        MV_UP   = 2'd1,
        MV_END  = 2'd2,
        MV_DOWN = 2'd3
    } t_move;

    typedef struct packed {
        logic  insert;
        logic  split;
        t_move move;
        logic  last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic up_done;
        logic split_zero;
        logic idx_zero;
    } t_dp_sts;

endpackage

### rtl/sdsch_ctrl.sv
module sdsch_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last_request,
    output logic               o_in_stall,
    input  sdsch_pkg::t_dp_sts i_sts,
    output sdsch_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SPLIT,
        S_UP,
        S_DOWN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;
    logic   accept;

    assign accept     = i_in_valid && !r_in_stall;
    assign o_in_stall = r_in_stall;

    always_comb begin
        n_state      = r_state;
        n_in_stall   = r_in_stall;
        o_cmd.insert = 1'b0;
        o_cmd.split  = 1'b0;
        o_cmd.move   = sdsch_pkg::MV_NONE;
        o_cmd.last   = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    o_cmd.insert = 1'b1;
                    if (i_last_request) begin
                        n_state    = S_SPLIT;
                        n_in_stall = 1'b1;
                    end
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_UP;
            end
            S_UP: begin
                if (i_sts.out_free) begin
                    if (i_sts.up_done) begin
                        o_cmd.move = sdsch_pkg::MV_END;
                        o_cmd.last = i_sts.split_zero;
                        if (i_sts.split_zero) begin
                            n_state    = S_LOAD;
                            n_in_stall = 1'b0;
                        end else begin
                            n_state = S_DOWN;
                        end
                    end else begin
                        o_cmd.move = sdsch_pkg::MV_UP;
                    end
                end
            end
            S_DOWN: begin
                if (i_sts.out_free) begin
                    o_cmd.move = sdsch_pkg::MV_DOWN;
                    o_cmd.last = i_sts.idx_zero;
                    if (i_sts.idx_zero) begin
                        n_state    = S_LOAD;
                        n_in_stall = 1'b0;
                    end
                end
            end
            default: begin
                n_state    = S_LOAD;
                n_in_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

endmodule

### rtl/sdsch_dp.sv
module sdsch_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sdsch_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sdsch_pkg::POS_W-1:0]            i_cfg_data,
    input  logic [sdsch_pkg::POS_W-1:0]            i_request_pos,
    input  sdsch_pkg::t_dp_cmd                     i_cmd,
    output sdsch_pkg::t_dp_sts                     o_sts,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic [sdsch_pkg::POS_W-1:0]            o_from_pos,
    output logic [sdsch_pkg::POS_W-1:0]            o_to_pos,
    output logic [sdsch_pkg::POS_W-1:0]            o_move_distance,
    output logic [sdsch_pkg::SUM_W-1:0]            o_total_seek,
    output logic                                   o_last_move
);

    localparam int N = sdsch_pkg::MAX_REQUESTS;

    logic [sdsch_pkg::POS_W-1:0] r_disk_end, r_head_start;
    logic [sdsch_pkg::POS_W-1:0] r_store [N];
    logic [sdsch_pkg::POS_W-1:0] n_store [N];
    logic [sdsch_pkg::CNT_W-1:0] r_cnt, r_idx, r_split, n_split;
    logic [sdsch_pkg::POS_W-1:0] r_head;
    logic [sdsch_pkg::SUM_W-1:0] r_sum;
    logic                        r_out_valid;
    logic [sdsch_pkg::POS_W-1:0] r_from, r_to, r_dist;
    logic [sdsch_pkg::SUM_W-1:0] r_seek;
    logic                        r_last;

    logic [N-1:0]                gt, lt;
    logic                        full;
    logic [sdsch_pkg::POS_W-1:0] rd, sat, to_val, move_len;
    logic [sdsch_pkg::SUM_W-1:0] sum_next;
    logic                        emit;

    assign full = (r_cnt == sdsch_pkg::CNT_W'(N));
    assign emit = (i_cmd.move != sdsch_pkg::MV_NONE);

    // Sorted insertion: entries above the new word shift up one slot.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            gt[i] = (sdsch_pkg::CNT_W'(i) < r_cnt) && (r_store[i] > i_request_pos);
        end
        for (int i = 0; i < N; i++) begin
            n_store[i] = r_store[i];
            if (gt[i] || (sdsch_pkg::CNT_W'(i) == r_cnt)) begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                    n_store[i] = r_store[(i > 0) ? i - 1 : 0];
                end else begin
                    n_store[i] = i_request_pos;
                end
            end
        end
    end

    // Split point: requests that land below the head after clamping to the end.
    always_comb begin
        n_split = '0;
        for (int i = 0; i < N; i++) begin
            lt[i] = (sdsch_pkg::CNT_W'(i) < r_cnt)
                    && ((r_store[i] < r_head_start) || (r_disk_end < r_head_start));
        end
        for (int i = 0; i < N; i++) begin
            if (lt[i]) begin
                n_split = sdsch_pkg::CNT_W'(i + 1);
            end
        end
    end

    assign rd       = r_store[r_idx[sdsch_pkg::IDX_W-1:0]];
    assign sat      = (rd > r_disk_end) ? r_disk_end : rd;
    assign to_val   = (i_cmd.move == sdsch_pkg::MV_END) ? r_disk_end : sat;
    assign move_len = (to_val >= r_head) ? (to_val - r_head) : (r_head - to_val);
    assign sum_next = r_sum + sdsch_pkg::SUM_W'(move_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_end   <= sdsch_pkg::DISK_END_RST;
            r_head_start <= sdsch_pkg::HEAD_START_RST;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_head       <= '0;
            r_idx        <= '0;
            r_split      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (sdsch_pkg::t_cfg_reg'(i_cfg_idx))
                    sdsch_pkg::CFG_DISK_END:   r_disk_end   <= i_cfg_data;
                    sdsch_pkg::CFG_HEAD_START: r_head_start <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.insert && !full) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.split) begin
                r_split <= n_split;
                r_idx   <= n_split;
                r_head  <= r_head_start;
                r_sum   <= '0;
            end
            if (emit) begin
                r_head <= to_val;
                r_sum  <= sum_next;
                unique case (i_cmd.move)
                    sdsch_pkg::MV_UP:   r_idx <= r_idx + 1'b1;
                    sdsch_pkg::MV_END:  r_idx <= r_split - 1'b1;
                    sdsch_pkg::MV_DOWN: r_idx <= r_idx - 1'b1;
                    default: ;
                endcase
                if (i_cmd.last) begin
                    r_cnt <= '0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: request store and output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !full) begin
            for (int i = 0; i < N; i++) begin
                r_store[i] <= n_store[i];
            end
        end
        if (emit) begin
            r_from <= r_head;
            r_to   <= to_val;
            r_dist <= move_len;
            r_seek <= sum_next;
            r_last <= i_cmd.last;
        end
    end

    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_sts.up_done    = (r_idx == r_cnt);
    assign o_sts.split_zero = (r_split == '0);
    assign o_sts.idx_zero   = (r_idx == '0);

    assign o_out_valid     = r_out_valid;
    assign o_from_pos      = r_from;
    assign o_to_pos        = r_to;
    assign o_move_distance = r_dist;
    assign o_total_seek    = r_seek;
    assign o_last_move     = r_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sdsch_pkg::CNT_W'(N))
        else $error("request count above store depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || !i_out_stall))
        else $error("move issued over a held output word");

    a_up_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.move == sdsch_pkg::MV_UP) |-> (r_idx < r_cnt))
        else $error("ascending read past stored requests");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && i_cmd.last) |=> (r_cnt == '0))
        else $error("store not emptied after final move");

endmodule

### rtl/scan_disk_scheduler.sv
// SCAN (elevator) disk scheduler for one batch of cylinder requests.
// Input channel: one word per request (request_pos, last_request), taken
// when i_in_valid is high and o_in_stall is low. Requests load at one per
// cycle into a 16-entry store kept sorted by insertion; a word past a full
// store is dropped, but its last_request flag still closes the batch.
// On the closing word the block raises o_in_stall, finds the split against
// head_start in a split state, then issues n+1 moves: ascending requests
// at or above the head, a sweep to disk_end, then the lower requests in
// descending order. Requests above disk_end are clamped to it.
// Output channel: one word per move (from, to, distance, running seek,
// last_move), held in an output register; a move leaves at one per cycle
// while i_out_stall is low, and i_out_stall simply holds the word and the
// sequencer. The input stays stalled from the closing word until the last
// move is issued, so the next batch loads only after this one is through;
// moves read the request store through its single read port. Write
// disk_end (index 0) and head_start (index 1) only while idle. Reset
// (synchronous, active low) empties the store, restores disk_end 199 and
// head_start 0, and drops any pending output word.
module scan_disk_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sdsch_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sdsch_pkg::POS_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [sdsch_pkg::POS_W-1:0]     i_request_pos,
    input  logic                            i_last_request,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sdsch_pkg::POS_W-1:0]     o_from_pos,
    output logic [sdsch_pkg::POS_W-1:0]     o_to_pos,
    output logic [sdsch_pkg::POS_W-1:0]     o_move_distance,
    output logic [sdsch_pkg::SUM_W-1:0]     o_total_seek,
    output logic                            o_last_move
);

    sdsch_pkg::t_dp_cmd cmd;
    sdsch_pkg::t_dp_sts sts;

    // Sequence load, split and the three move phases.
    sdsch_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_last_request (i_last_request),
        .o_in_stall     (o_in_stall),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    // Hold the sorted store, head position, seek total and output word.
    sdsch_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_request_pos   (i_request_pos),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_from_pos      (o_from_pos),
        .o_to_pos        (o_to_pos),
        .o_move_distance (o_move_distance),
        .o_total_seek    (o_total_seek),
        .o_last_move     (o_last_move)
    );

endmodule
